FILE: rtl/core/lt3d_pkg.sv
// shared types and constants of the 3d lookup table color mapper
package lt3d_pkg;

	localparam int MAX_GRID   = 33;
	localparam int CUBE_DEPTH = MAX_GRID * MAX_GRID * MAX_GRID;
	localparam int ADDR_W     = 16;
	localparam int ENTRY_W    = 24;
	localparam int CORNERS    = 8;

	// operation codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_PIXEL = 1'b1;

	localparam logic [5:0]  GRID_MIN   = 6'd2;
	localparam logic [5:0]  GRID_MAX   = 6'(MAX_GRID);
	localparam logic [5:0]  GRID_RESET = 6'd33;
	localparam logic [7:0]  ALPHA      = 8'hFF;

	// divide by 255^3: q = (acc * RECIP) >> RECIP_SHIFT, then one correction
	localparam logic [23:0] DENOM3      = 24'd16581375;
	localparam logic [31:0] RECIP       = 32'd2172847367;
	localparam int          RECIP_SHIFT = 55;

	typedef struct packed {
		logic        operation;
		logic [15:0] entry_index;
		logic [7:0]  entry_red;
		logic [7:0]  entry_green;
		logic [7:0]  entry_blue;
		logic [7:0]  pixel_red;
		logic [7:0]  pixel_green;
		logic [7:0]  pixel_blue;
	} pix_req_t;

	typedef struct packed {
		logic [7:0] out_alpha;
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
	} res_data_t;

endpackage

FILE: rtl/core/lt3d_ram.sv
// one replica of the color cube: one write port, one registered read port
module lt3d_ram (
	input  logic                         clk,
	input  logic                         we,
	input  logic [lt3d_pkg::ADDR_W-1:0]  waddr,
	input  logic [lt3d_pkg::ENTRY_W-1:0] wdata,
	input  logic                         re,
	input  logic [lt3d_pkg::ADDR_W-1:0]  raddr,
	output logic [lt3d_pkg::ENTRY_W-1:0] rdata
);
	import lt3d_pkg::*;

	logic [ENTRY_W-1:0] mem [CUBE_DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/lut3d_trilinear_color_map_top.sv
// top level of the 3d lookup table color mapper with trilinear blending
//
// Usage:
// - pix channel (pix_valid, pix_stall, pix_req) takes write and pixel
//   requests. A write request loads one cube entry at the flat index
//   x + y*N + z*N*N; an index beyond the cube is dropped. A pixel request
//   reads the eight surrounding grid entries and blends them.
// - res channel (res_valid, res_stall, res_data) gives one result per
//   pixel request, in order, alpha fixed at 255. Writes give no result.
// - cfg channel (cfg_valid, cfg_ready, cfg_data) sets the grid size N;
//   cfg_ready is always high. Write it only while the pipeline is empty.
// Timing: a ten stage pipeline; a pixel result leaves its last stage. One
// request is taken every cycle unless the pipeline holds (see below). The
// eight corner reads are served at once by eight copies of the cube, all
// written together by each write request.
// Reset clears all valid bits and sets N to 33; cube contents stay
// undefined until written. While res_stall holds a waiting result the
// whole pipeline holds, and pix_stall is raised; nothing is lost.
module lut3d_trilinear_color_map_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pix_valid,
	output logic                pix_stall,
	input  lt3d_pkg::pix_req_t  pix_req,
	output logic                res_valid,
	input  logic                res_stall,
	output lt3d_pkg::res_data_t res_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [5:0]          cfg_data
);
	import lt3d_pkg::*;

	logic              adv;
	logic [5:0]        lut_size_q;
	logic [5:0]        grid_n;
	logic [5:0]        grid_nm1;
	logic [10:0]       nn_q;

	logic              v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	pix_req_t          req_s1, req_s2, req_s3, req_s4;
	logic [12:0]       p_s2 [3];
	logic [5:0]        lo_s3 [3];
	logic [5:0]        hi_s3 [3];
	logic [7:0]        fr_s3 [3];
	logic [5:0]        x_s4 [2];
	logic [10:0]       yn_s4 [2];
	logic [15:0]       zn_s4 [2];
	logic [15:0]       wxy_s4 [4];
	logic [7:0]        wz_s4 [2];
	logic [23:0]       w_s5 [CORNERS];
	logic [ADDR_W-1:0] addr [CORNERS];
	logic [ENTRY_W-1:0] rd [CORNERS];
	logic [31:0]       prod_s6 [CORNERS][3];
	logic [31:0]       pair_s7 [4][3];
	logic [31:0]       acc_s8 [3];
	logic [31:0]       acc_s9 [3];
	logic [7:0]        q_s9 [3];
	logic [7:0]        col_s10 [3];
	logic              wr_en;

	// lower grid corner, p / 255 for p below 2^13
	function automatic logic [5:0] lo_of(input logic [12:0] p);
		logic [13:0] s;
		s = 14'(p) + 14'(p >> 8) + 14'd1;
		return 6'(s >> 8);
	endfunction

	// upper grid corner, clamped to the last grid point
	function automatic logic [5:0] hi_of(input logic [5:0] lo, input logic [5:0] n);
		logic [6:0] up;
		up = 7'(lo) + 7'd1;
		return (up >= 7'(n)) ? 6'(n - 6'd1) : 6'(up);
	endfunction

	// handshake
	assign adv       = !res_valid || !res_stall;
	assign pix_stall = !adv;
	assign cfg_ready = 1'b1;

	// grid size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lut_size_q <= GRID_RESET;
		end else if (cfg_valid && cfg_ready) begin
			lut_size_q <= cfg_data;
		end
	end

	always_comb begin
		if (lut_size_q < GRID_MIN) begin
			grid_n = GRID_MIN;
		end else if (lut_size_q > GRID_MAX) begin
			grid_n = GRID_MAX;
		end else begin
			grid_n = lut_size_q;
		end
		grid_nm1 = grid_n - 6'd1;
	end

	// plane stride, settles while the pipeline is idle after a config write
	always_ff @(posedge clk) begin
		nn_q <= 11'(grid_n) * 11'(grid_n);
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
			v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0; v_s9 <= 1'b0; v_s10 <= 1'b0;
		end else if (adv) begin
			v_s1  <= pix_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			// only pixel requests go on past the cube
			v_s5  <= v_s4 && (req_s4.operation == OP_PIXEL);
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	// stages 1 to 4: scale, split into corner and fraction, strides, weights
	always_ff @(posedge clk) begin
		if (adv) begin
			req_s1 <= pix_req;
			req_s2 <= req_s1;
			req_s3 <= req_s2;
			req_s4 <= req_s3;
			p_s2[0] <= 13'(req_s1.pixel_red) * 13'(grid_nm1);
			p_s2[1] <= 13'(req_s1.pixel_green) * 13'(grid_nm1);
			p_s2[2] <= 13'(req_s1.pixel_blue) * 13'(grid_nm1);
			for (int a = 0; a < 3; a++) begin
				lo_s3[a] <= lo_of(p_s2[a]);
				fr_s3[a] <= 8'(p_s2[a] - ((13'(lo_of(p_s2[a])) << 8) - 13'(lo_of(p_s2[a]))));
				hi_s3[a] <= hi_of(lo_of(p_s2[a]), grid_n);
			end
			x_s4[0]  <= lo_s3[0];
			x_s4[1]  <= hi_s3[0];
			yn_s4[0] <= 11'(lo_s3[1]) * 11'(grid_n);
			yn_s4[1] <= 11'(hi_s3[1]) * 11'(grid_n);
			zn_s4[0] <= 16'(lo_s3[2]) * 16'(nn_q);
			zn_s4[1] <= 16'(hi_s3[2]) * 16'(nn_q);
			wxy_s4[0] <= 16'(8'(8'hFF - fr_s3[0])) * 16'(8'(8'hFF - fr_s3[1]));
			wxy_s4[1] <= 16'(fr_s3[0]) * 16'(8'(8'hFF - fr_s3[1]));
			wxy_s4[2] <= 16'(8'(8'hFF - fr_s3[0])) * 16'(fr_s3[1]);
			wxy_s4[3] <= 16'(fr_s3[0]) * 16'(fr_s3[1]);
			wz_s4[0]  <= 8'hFF - fr_s3[2];
			wz_s4[1]  <= fr_s3[2];
		end
	end

	// corner addresses, bit 0 picks x, bit 1 y, bit 2 z
	always_comb begin
		for (int c = 0; c < CORNERS; c++) begin
			addr[c] = 16'(x_s4[c & 1]) + 16'(yn_s4[(c >> 1) & 1]) + zn_s4[(c >> 2) & 1];
		end
	end

	assign wr_en = adv && v_s4 && (req_s4.operation == OP_WRITE)
		&& (32'(req_s4.entry_index) < CUBE_DEPTH);

	// eight copies of the cube, one per corner
	for (genvar g = 0; g < CORNERS; g++) begin : g_cube
		lt3d_ram u_ram (
			.clk   (clk),
			.we    (wr_en),
			.waddr (req_s4.entry_index),
			.wdata ({req_s4.entry_red, req_s4.entry_green, req_s4.entry_blue}),
			.re    (adv),
			.raddr (addr[g]),
			.rdata (rd[g])
		);
	end

	// stages 5 to 8: corner weights, products, adder tree
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < CORNERS; c++) begin
				w_s5[c] <= 24'(wxy_s4[c & 3]) * 24'(wz_s4[(c >> 2) & 1]);
				for (int ch = 0; ch < 3; ch++) begin
					prod_s6[c][ch] <= 32'(rd[c][ENTRY_W-1-8*ch -: 8]) * 32'(w_s5[c]);
				end
			end
			for (int ch = 0; ch < 3; ch++) begin
				for (int k = 0; k < 4; k++) begin
					pair_s7[k][ch] <= prod_s6[2*k][ch] + prod_s6[2*k+1][ch];
				end
				acc_s8[ch] <= pair_s7[0][ch] + pair_s7[1][ch] + pair_s7[2][ch]
					+ pair_s7[3][ch];
			end
		end
	end

	// stages 9 and 10: divide by 255^3 through the reciprocal, then correct
	always_ff @(posedge clk) begin
		logic [63:0] qp;
		logic [31:0] rem;
		if (adv) begin
			for (int ch = 0; ch < 3; ch++) begin
				qp = 64'(acc_s8[ch]) * 64'(RECIP);
				q_s9[ch]   <= qp[RECIP_SHIFT+7:RECIP_SHIFT];
				acc_s9[ch] <= acc_s8[ch];
				rem = acc_s9[ch] - 32'(q_s9[ch]) * 32'(DENOM3);
				col_s10[ch] <= (rem >= 32'(DENOM3)) ? q_s9[ch] + 8'd1 : q_s9[ch];
			end
		end
	end

	assign res_valid          = v_s10;
	assign res_data.out_alpha = ALPHA;
	assign res_data.out_red   = col_s10[0];
	assign res_data.out_green = col_s10[1];
	assign res_data.out_blue  = col_s10[2];

endmodule

FILE: verif/lut3d_trilinear_color_map_top_test.sv
// testbench for the 3d lookup table color mapper: random traffic checked against a predictor
module lut3d_trilinear_color_map_top_test;
	timeunit 1ns;
	timeprecision 1ps;
	import lt3d_pkg::*;

	// expected pixel results and a private copy of the cube and grid size
	class grade_tracker;
		bit [23:0] cube [CUBE_DEPTH];
		bit written [CUBE_DEPTH];
		bit [5:0] size_reg;
		res_data_t pending [$];
		int errors;

		function new();
			size_reg = GRID_RESET;
			errors = 0;
		endfunction

		function void set_size(bit [5:0] v);
			size_reg = v;
		endfunction

		// grid points per axis after clamping
		function int unsigned grid();
			if (size_reg < GRID_MIN) return 32'(GRID_MIN);
			if (size_reg > GRID_MAX) return 32'(GRID_MAX);
			return 32'(size_reg);
		endfunction

		// flat index of one of the eight corners a pixel reads
		function int unsigned corner_at(pix_req_t r, int k);
			int unsigned n, p, lo, hi;
			int unsigned c [3];
			bit [7:0] comp [3];
			n = grid();
			comp[0] = r.pixel_red;
			comp[1] = r.pixel_green;
			comp[2] = r.pixel_blue;
			for (int a = 0; a < 3; a++) begin
				p = comp[a] * (n - 1);
				lo = p / 255;
				hi = (lo + 1 >= n) ? n - 1 : lo + 1;
				c[a] = k[a] ? hi : lo;
			end
			return c[0] + c[1] * n + c[2] * n * n;
		endfunction

		// trilinear blend of the eight corners, exact over 255^3
		function res_data_t blend(pix_req_t r);
			int unsigned n, p, idx;
			int unsigned lo [3], hi [3], fr [3], c [3];
			bit [7:0] comp [3];
			longint unsigned acc [3], w, q;
			res_data_t d;
			n = grid();
			comp[0] = r.pixel_red;
			comp[1] = r.pixel_green;
			comp[2] = r.pixel_blue;
			for (int a = 0; a < 3; a++) begin
				p = comp[a] * (n - 1);
				lo[a] = p / 255;
				fr[a] = p % 255;
				hi[a] = (lo[a] + 1 >= n) ? n - 1 : lo[a] + 1;
				acc[a] = 0;
			end
			for (int k = 0; k < 8; k++) begin
				w = 1;
				for (int a = 0; a < 3; a++) begin
					c[a] = k[a] ? hi[a] : lo[a];
					w = w * (k[a] ? fr[a] : 255 - fr[a]);
				end
				idx = c[0] + c[1] * n + c[2] * n * n;
				acc[0] += cube[idx][23:16] * w;
				acc[1] += cube[idx][15:8] * w;
				acc[2] += cube[idx][7:0] * w;
			end
			d.out_alpha = ALPHA;
			q = acc[0] / DENOM3;
			d.out_red = (q > 255) ? 8'd255 : q[7:0];
			q = acc[1] / DENOM3;
			d.out_green = (q > 255) ? 8'd255 : q[7:0];
			q = acc[2] / DENOM3;
			d.out_blue = (q > 255) ? 8'd255 : q[7:0];
			return d;
		endfunction

		// accepted request: update the cube or queue the blended pixel
		function void note(pix_req_t r);
			if (r.operation == OP_WRITE) begin
				if (r.entry_index < CUBE_DEPTH) begin
					cube[r.entry_index] = {r.entry_red, r.entry_green, r.entry_blue};
					written[r.entry_index] = 1'b1;
				end
			end else
				pending.push_back(blend(r));
		endfunction

		function void check(res_data_t got);
			res_data_t want;
			if (pending.size() == 0) begin
				$error("result with nothing pending: %h", got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.out_alpha !== want.out_alpha) begin
				$error("out_alpha expected %0d got %0d", want.out_alpha, got.out_alpha);
				errors++;
			end
			if (got.out_red !== want.out_red) begin
				$error("out_red expected %0d got %0d", want.out_red, got.out_red);
				errors++;
			end
			if (got.out_green !== want.out_green) begin
				$error("out_green expected %0d got %0d", want.out_green, got.out_green);
				errors++;
			end
			if (got.out_blue !== want.out_blue) begin
				$error("out_blue expected %0d got %0d", want.out_blue, got.out_blue);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic pix_valid = 0;
	logic pix_stall;
	pix_req_t pix_req = '0;
	logic res_valid;
	logic res_stall = 0;
	res_data_t res_data;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [5:0] cfg_data = '0;

	grade_tracker sb = new();
	bit quiet_sink = 0;
	int stall_left = 0;
	int sent = 0;

	lut3d_trilinear_color_map_top uut (
		.clk(clk), .arst_n(arst_n),
		.pix_valid(pix_valid), .pix_stall(pix_stall), .pix_req(pix_req),
		.res_valid(res_valid), .res_stall(res_stall), .res_data(res_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// result sink with random back-pressure, short mostly, a few long
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			sb.check(res_data);
		if (quiet_sink) begin
			res_stall <= 0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			res_stall <= 1;
		end else if ($urandom_range(3) == 0) begin
			stall_left <= ($urandom_range(19) == 0) ? $urandom_range(60, 20) : $urandom_range(2);
			res_stall <= 1;
		end else
			res_stall <= 0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 75) return 0;
		if (r < 96) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// present one request, hold it until taken, then optional idle cycles
	task automatic send(pix_req_t r, int gap);
		pix_req <= r;
		pix_valid <= 1;
		do @(posedge clk); while (pix_stall);
		sb.note(r);
		sent++;
		if (gap > 0) begin
			pix_valid <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic put_entry(int unsigned idx, bit [23:0] rgb, int gap);
		pix_req_t r;
		r = pix_req_t'(65'({$urandom, $urandom, $urandom}));
		r.operation = OP_WRITE;
		r.entry_index = 16'(idx);
		{r.entry_red, r.entry_green, r.entry_blue} = rgb;
		send(r, gap);
	endtask

	// load any corner the pixel reads that holds nothing yet, then the pixel
	task automatic map_pixel(bit [23:0] rgb, int gap);
		pix_req_t r;
		int unsigned idx;
		r = pix_req_t'(65'({$urandom, $urandom, $urandom}));
		r.operation = OP_PIXEL;
		{r.pixel_red, r.pixel_green, r.pixel_blue} = rgb;
		for (int k = 0; k < 8; k++) begin
			idx = sb.corner_at(r, k);
			if (!sb.written[idx])
				put_entry(idx, 24'($urandom), 0);
		end
		send(r, gap);
	endtask

	function automatic bit [7:0] pick_byte();
		int r;
		r = $urandom_range(9);
		if (r == 0) return 8'd0;
		if (r == 1) return 8'd255;
		return 8'($urandom_range(255));
	endfunction

	// drain the pipeline, then load a new grid size
	task automatic set_grid(bit [5:0] v);
		pix_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (14) @(posedge clk);
		cfg_data <= v;
		cfg_valid <= 1;
		do @(posedge clk); while (!cfg_ready);
		sb.set_size(v);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	// mixed random traffic, mostly pixels, until count more requests went in
	task automatic random_burst(int count);
		int stop;
		int i;
		stop = sent + count;
		i = 0;
		while (sent < stop) begin
			if (i % 40 == 20) quiet_sink = ~quiet_sink;
			if ($urandom_range(99) < 70)
				map_pixel({pick_byte(), pick_byte(), pick_byte()}, pick_gap());
			else if ($urandom_range(19) == 0)
				put_entry($urandom_range(65535, CUBE_DEPTH), 24'($urandom), pick_gap());
			else
				put_entry($urandom_range(CUBE_DEPTH - 1), 24'($urandom), pick_gap());
			i++;
		end
		quiet_sink = 0;
	endtask

	initial begin
		bit [5:0] sizes [7];
		sizes = '{6'd2, 6'd33, 6'd17, 6'd0, 6'd63, 6'd5, 6'd0};
		sizes[6] = 6'($urandom_range(63));
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, out-of-store writes, corner entries
		put_entry(0, 24'hFF00FF, 0);
		put_entry(CUBE_DEPTH - 1, 24'h00FF00, 1);
		map_pixel(24'h000000, 0);
		map_pixel(24'hFFFFFF, 0);
		map_pixel(24'hFF0080, 2);
		map_pixel(24'h01FE7F, 0);
		put_entry(CUBE_DEPTH, 24'h123456, 0);
		put_entry(16'hFFFF, 24'hFFFFFF, 0);
		map_pixel(24'h000000, 0);
		map_pixel(24'hFFFFFF, 0);
		put_entry(0, 24'h000000, 0);
		put_entry(CUBE_DEPTH - 1, 24'hFFFFFF, 0);
		map_pixel(24'h000000, 0);
		map_pixel(24'hFFFFFF, 0);
		map_pixel(24'h80FF00, 0);
		map_pixel(24'h7F7F7F, 3);
		random_burst(80);

		foreach (sizes[k]) begin
			set_grid(sizes[k]);
			map_pixel(24'h000000, 0);
			map_pixel(24'hFFFFFF, 0);
			map_pixel(24'hFF00FF, 0);
			random_burst(80);
		end
		pix_valid <= 0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#30ms;
		$display("TEST FAILED");
		$finish;
	end
endmodule
